// ===== src/nnd_pkg.sv =====
`default_nettype none

package nnd_pkg;

   // configuration register width and texel port width
   localparam int REG_W   = 13;
   localparam int TEXEL_W = 32;
   localparam int CSR_IDX_W = 4;

   localparam int DEF_MAX_DIM     = 4096;
   localparam int DEF_TEXEL_BYTES = 4;

   // largest value a register can hold
   localparam int REG_MAX = (1 << REG_W) - 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 4'd0,
      CSR_SOURCE_HEIGHT = 4'd1,
      CSR_TARGET_WIDTH  = 4'd2,
      CSR_TARGET_HEIGHT = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic [TEXEL_W-1:0] texel;
      logic               row_end;
      logic               frame_end;
   } rsp_item_type;

   // saturate a register value into 1..max_dim
   function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v,
                                                  input int max_dim);
      logic [REG_W-1:0] r;
      if (v == '0) begin
         r = REG_W'(1);
      end else if (int'(v) > max_dim) begin
         r = REG_W'(max_dim);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic dim_in_range(input logic [REG_W-1:0] v, input int max_dim);
      return (v != '0) && (int'(v) <= max_dim);
   endfunction

endpackage

`default_nettype wire

// ===== src/nearest_neighbor_downscaler.sv =====
// Point-sampled frame downscaler.
// req_ channel: source texels in raster order, one transfer per texel.
// rsp_ channel: the picked texels in raster order of the smaller frame, each
//   with rsp_row_end on the last texel of an output row and rsp_frame_end on
//   the last texel of the frame. Source texels that are not picked give nothing.
// csr_ channel: register index 0..3 = source width, source height, target width,
//   target height (13 bits each), always ready; the user must write only while idle
//   (the block does not enforce this). A target larger than its source, or a
//   value outside 1..MAX_DIM, stops all output while the counters keep running.
// Output: a picked texel is registered before it appears on rsp_valid.
// Throughput: one texel per cycle while req_ready is high; the selection is a set of
//   add-and-compare accumulators updated in the cycle of the transfer.
// Reset: registers return to 1 and all position counters to zero; no result
//   is pending. Counters wrap to a new frame after width*height texels.
// Stall: a two-entry output register absorbs one result beyond the one on
//   rsp_; req_ready drops while both are held and rises as rsp_ drains.
`default_nettype none

module nearest_neighbor_downscaler
   import nnd_pkg::*;
#(
   parameter int MAX_DIM     = DEF_MAX_DIM,
   parameter int TEXEL_BYTES = DEF_TEXEL_BYTES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [TEXEL_W-1:0]   req_texel_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [TEXEL_W-1:0]        rsp_texel_out,
   output logic                      rsp_row_end,
   output logic                      rsp_frame_end,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata
);

   localparam int DIM_CAP = (MAX_DIM < REG_MAX) ? MAX_DIM : REG_MAX;
   localparam int DIM_W   = $clog2(DIM_CAP + 1);

   logic [DIM_W-1:0] sw, sh, dw, dh;
   logic             usable;
   logic             accept, push, can_push;
   rsp_item_type     push_item, rsp_item;

   assign req_ready = can_push;
   assign accept    = req_valid && req_ready;

   nnd_csr #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sw        (sw),
      .sh        (sh),
      .dw        (dw),
      .dh        (dh),
      .usable    (usable)
   );

   nnd_sel #(
      .TEXEL_BYTES (TEXEL_BYTES),
      .DIM_W       (DIM_W)
   ) u_sel (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .texel_in (req_texel_in),
      .sw       (sw),
      .sh       (sh),
      .dw       (dw),
      .dh       (dh),
      .usable   (usable),
      .push     (push),
      .item     (push_item)
   );

   nnd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .can_push  (can_push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_texel_out = rsp_item.texel;
   assign rsp_row_end   = rsp_item.row_end;
   assign rsp_frame_end = rsp_item.frame_end;

endmodule

`default_nettype wire

// ===== src/nnd_csr.sv =====
`default_nettype none

module nnd_csr
   import nnd_pkg::*;
#(
   parameter int MAX_DIM = DEF_MAX_DIM,
   parameter int DIM_W   = 13
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata,
   output logic [DIM_W-1:0]          sw,
   output logic [DIM_W-1:0]          sh,
   output logic [DIM_W-1:0]          dw,
   output logic [DIM_W-1:0]          dh,
   output logic                      usable
);

   logic [REG_W-1:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [REG_W-1:0] src_w_in, src_h_in, dst_w_in, dst_h_in;
   logic             wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid;

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      if (wr) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_in = csr_wdata;
            CSR_SOURCE_HEIGHT: src_h_in = csr_wdata;
            CSR_TARGET_WIDTH:  dst_w_in = csr_wdata;
            CSR_TARGET_HEIGHT: dst_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= REG_W'(1);
         src_h_ff <= REG_W'(1);
         dst_w_ff <= REG_W'(1);
         dst_h_ff <= REG_W'(1);
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         dst_w_ff <= dst_w_in;
         dst_h_ff <= dst_h_in;
      end
   end

   // clamped values always fit the counter width
   assign sw = DIM_W'(clamp_dim(src_w_ff, MAX_DIM));
   assign sh = DIM_W'(clamp_dim(src_h_ff, MAX_DIM));
   assign dw = DIM_W'(clamp_dim(dst_w_ff, MAX_DIM));
   assign dh = DIM_W'(clamp_dim(dst_h_ff, MAX_DIM));

   assign usable = dim_in_range(src_w_ff, MAX_DIM) && dim_in_range(src_h_ff, MAX_DIM) &&
                   dim_in_range(dst_w_ff, MAX_DIM) && dim_in_range(dst_h_ff, MAX_DIM) &&
                   (dw <= sw) && (dh <= sh);

endmodule

`default_nettype wire

// ===== src/nnd_sel.sv =====
`default_nettype none

module nnd_sel
   import nnd_pkg::*;
#(
   parameter int TEXEL_BYTES = DEF_TEXEL_BYTES,
   parameter int DIM_W       = 13
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [TEXEL_W-1:0] texel_in,
   input  wire logic [DIM_W-1:0]   sw,
   input  wire logic [DIM_W-1:0]   sh,
   input  wire logic [DIM_W-1:0]   dw,
   input  wire logic [DIM_W-1:0]   dh,
   input  wire logic               usable,
   output logic                    push,
   output rsp_item_type            item
);

   localparam int ACC_W = 2 * DIM_W;
   localparam logic [TEXEL_W-1:0] TEXEL_MASK =
      TEXEL_W'((64'd1 << (8 * TEXEL_BYTES)) - 64'd1);

   logic [DIM_W-1:0] src_col_ff, src_row_ff, out_col_ff, out_row_ff;
   logic [DIM_W-1:0] src_col_in, src_row_in, out_col_in, out_row_in;
   logic [ACC_W-1:0] col_bound_acc_ff, col_pick_acc_ff, row_bound_acc_ff, row_pick_acc_ff;
   logic [ACC_W-1:0] col_bound_acc_in, col_pick_acc_in, row_bound_acc_in, row_pick_acc_in;

   logic             col_pick, row_pick;
   logic [ACC_W:0]   col_limit, row_limit;
   logic [DIM_W:0]   out_col_inc, out_row_inc;

   assign col_limit = {1'b0, col_bound_acc_ff} + (ACC_W + 1)'(dw);
   assign row_limit = {1'b0, row_bound_acc_ff} + (ACC_W + 1)'(dh);
   assign col_pick  = (out_col_ff < dw) && ({1'b0, col_pick_acc_ff} < col_limit);
   assign row_pick  = (out_row_ff < dh) && ({1'b0, row_pick_acc_ff} < row_limit);

   assign out_col_inc = {1'b0, out_col_ff} + (DIM_W + 1)'(1);
   assign out_row_inc = {1'b0, out_row_ff} + (DIM_W + 1)'(1);

   assign push           = accept && usable && row_pick && col_pick;
   assign item.texel     = texel_in & TEXEL_MASK;
   assign item.row_end   = (out_col_ff == dw - DIM_W'(1));
   assign item.frame_end = item.row_end && (out_row_ff == dh - DIM_W'(1));

   always_comb begin
      src_col_in       = src_col_ff;
      src_row_in       = src_row_ff;
      out_col_in       = out_col_ff;
      out_row_in       = out_row_ff;
      col_bound_acc_in = col_bound_acc_ff;
      col_pick_acc_in  = col_pick_acc_ff;
      row_bound_acc_in = row_bound_acc_ff;
      row_pick_acc_in  = row_pick_acc_ff;

      if (accept) begin
         if (col_pick) begin
            out_col_in = DIM_W'(out_col_inc);
            // pick accumulator stops once the row has all its picks
            if (out_col_inc < (DIM_W + 1)'(dw)) begin
               col_pick_acc_in = col_pick_acc_ff + ACC_W'(sw);
            end
         end

         if (src_col_ff >= sw - DIM_W'(1)) begin
            src_col_in       = '0;
            col_bound_acc_in = '0;
            col_pick_acc_in  = '0;
            out_col_in       = '0;
            if (row_pick) begin
               out_row_in = DIM_W'(out_row_inc);
               if (out_row_inc < (DIM_W + 1)'(dh)) begin
                  row_pick_acc_in = row_pick_acc_ff + ACC_W'(sh);
               end
            end
            if (src_row_ff >= sh - DIM_W'(1)) begin
               src_row_in       = '0;
               row_bound_acc_in = '0;
               row_pick_acc_in  = '0;
               out_row_in       = '0;
            end else begin
               src_row_in       = src_row_ff + DIM_W'(1);
               row_bound_acc_in = row_bound_acc_ff + ACC_W'(dh);
            end
         end else begin
            src_col_in       = src_col_ff + DIM_W'(1);
            col_bound_acc_in = col_bound_acc_ff + ACC_W'(dw);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff       <= '0;
         src_row_ff       <= '0;
         out_col_ff       <= '0;
         out_row_ff       <= '0;
         col_bound_acc_ff <= '0;
         col_pick_acc_ff  <= '0;
         row_bound_acc_ff <= '0;
         row_pick_acc_ff  <= '0;
      end else begin
         src_col_ff       <= src_col_in;
         src_row_ff       <= src_row_in;
         out_col_ff       <= out_col_in;
         out_row_ff       <= out_row_in;
         col_bound_acc_ff <= col_bound_acc_in;
         col_pick_acc_ff  <= col_pick_acc_in;
         row_bound_acc_ff <= row_bound_acc_in;
         row_pick_acc_ff  <= row_pick_acc_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/nnd_skid.sv =====
`default_nettype none

module nnd_skid
   import nnd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rsp_item_type  push_item,
   output logic               can_push,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_item_type       rsp_item
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         pop;

   assign pop       = out_valid_ff && rsp_ready;
   assign can_push  = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (pop || !out_valid_ff) begin
         // output slot frees up: the oldest waiting item moves in
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_item_in  = skid_item_ff;
            skid_valid_in = push;
            if (push) begin
               skid_item_in = push_item;
            end
         end else begin
            out_valid_in = push;
            if (push) begin
               out_item_in = push_item;
            end
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_item_in  = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

`default_nettype wire
